>>> hw/rtl/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared constants and types for the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

	localparam int NUM_CPUS_DEF   = 8;
	localparam int NUM_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [31:0] POOL_BASE_RST = 32'h8000_0000;
	localparam logic [31:0] POOL_TOP_RST  = 32'h8800_0000;

	// register indexes
	localparam logic REG_POOL_BASE = 1'b0;
	localparam logic REG_POOL_TOP  = 1'b1;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_ALLOCATED = 2'd0,
		STAT_FREED     = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_BAD_ADDR  = 2'd3
	} status_t;

endpackage

>>> hw/rtl/pcpa_link_ram.sv
// ----------------------------------------------------------------------------
// pcpa_link_ram
// Next-link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcpa_link_ram #(
	parameter int DEPTH = pcpa_pkg::NUM_PAGES_DEF,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/per_cpu_page_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_page_allocator
// Page-frame allocator with one LIFO free list per CPU: per-CPU heads in
// flops, next links in a synchronous memory indexed by page number.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, requester_cpu,       | request
//          | page_address                                     |
//  out     | out_valid, out_stall, status, granted_address    | response
//  cfg     | cfg_write_en, cfg_index, cfg_data                | write only
//
// One request at a time. A free (valid or rejected) or an empty allocate ends
// in EXEC; a successful allocate goes on to POP for the link memory read.
// A new word is taken while the previous response still waits in the output
// register; a stalled output holds the request in its last step.
// Reset empties all lists at once; the link memory needs no clearing pass.
module per_cpu_page_allocator #(
	parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
	parameter int NUM_PAGES  = pcpa_pkg::NUM_PAGES_DEF,
	parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [2:0]  requester_cpu,
	input  logic [31:0] page_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] granted_address,
	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PG_W  = $clog2(NUM_PAGES);
	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int PN_W  = 32 - OFF_W;
	localparam int FP_W  = PN_W + 1;
	localparam logic [FP_W-1:0] FIRST_PG_RST = FP_W'((64'(pcpa_pkg::POOL_BASE_RST)
		+ 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [FP_W-1:0]  first_pg_q;
	logic [31:0]      pool_top_q;

	logic [PG_W-1:0]     head_q [NUM_CPUS];
	logic [NUM_CPUS-1:0] head_vld_q;

	logic             op_q, none_q, bad_q;
	logic [CPU_W-1:0] tgt_q;
	logic [PG_W-1:0]  idx_q, pop_idx_q;

	logic                 out_valid_q;
	pcpa_pkg::status_t    status_q;
	logic [31:0]          granted_q;

	// ---- request decode at accept
	logic [2:0]            cpu_tmp;
	logic [CPU_W-1:0]      cpu_in, k, search_id, tgt_in;
	logic [CPU_W:0]        id_sum;
	logic [2*NUM_CPUS-1:0] vld2;
	logic [NUM_CPUS-1:0]   rot;
	logic [PN_W-1:0]       pg;
	logic [FP_W-1:0]       diff;
	logic                  bad_in;
	logic                  accept;

	assign accept = in_valid && !in_stall;

	always_comb begin
		cpu_tmp = requester_cpu;
		for (int i = 0; i < 8; i++) begin
			if (7'(cpu_tmp) >= 7'(NUM_CPUS)) begin
				cpu_tmp = cpu_tmp - 3'(NUM_CPUS);
			end
		end
		cpu_in = CPU_W'(cpu_tmp);

		vld2 = {head_vld_q, head_vld_q} >> cpu_in;
		rot  = vld2[NUM_CPUS-1:0];
		k    = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (rot[i]) begin
				k = CPU_W'(i);
			end
		end
		id_sum = {1'b0, cpu_in} + {1'b0, k};
		if (id_sum >= (CPU_W+1)'(NUM_CPUS)) begin
			id_sum = id_sum - (CPU_W+1)'(NUM_CPUS);
		end
		search_id = id_sum[CPU_W-1:0];
		tgt_in = (opcode == pcpa_pkg::OP_FREE) ? cpu_in : search_id;

		pg     = page_address[31:OFF_W];
		diff   = {1'b0, pg} - first_pg_q;
		bad_in = (|page_address[OFF_W-1:0]) || ({1'b0, pg} < first_pg_q)
			|| (page_address >= pool_top_q) || (33'(diff) >= 33'(NUM_PAGES));
	end

	// ---- execution
	logic slot_free;
	logic load_res;
	pcpa_pkg::status_t res_status;
	logic [31:0] res_granted;
	logic ram_we, ram_re;
	logic head_we, head_wvld;
	logic [PG_W-1:0] head_wdata;
	logic [PG_W-1:0] head_rd;
	logic [PG_W:0]   ram_rdata;
	logic [PN_W-1:0] pnum;

	assign slot_free = !out_valid_q || !out_stall;
	assign head_rd   = head_q[tgt_q];
	assign pnum      = PN_W'(first_pg_q) + PN_W'(pop_idx_q);

	always_comb begin
		state_d     = state_q;
		load_res    = 1'b0;
		res_status  = pcpa_pkg::STAT_EMPTY;
		res_granted = '0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		head_we     = 1'b0;
		head_wvld   = 1'b1;
		head_wdata  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == pcpa_pkg::OP_FREE) begin
					if (slot_free) begin
						load_res = 1'b1;
						state_d  = ST_IDLE;
						if (bad_q) begin
							res_status = pcpa_pkg::STAT_BAD_ADDR;
						end else begin
							res_status = pcpa_pkg::STAT_FREED;
							ram_we     = 1'b1;
							head_we    = 1'b1;
						end
					end
				end else if (none_q) begin
					if (slot_free) begin
						load_res   = 1'b1;
						res_status = pcpa_pkg::STAT_EMPTY;
						state_d    = ST_IDLE;
					end
				end else begin
					ram_re  = 1'b1;
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				if (slot_free) begin
					load_res    = 1'b1;
					res_status  = pcpa_pkg::STAT_ALLOCATED;
					res_granted = {pnum, {OFF_W{1'b0}}};
					head_we     = 1'b1;
					head_wdata  = ram_rdata[PG_W-1:0];
					head_wvld   = ram_rdata[PG_W];
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	pcpa_link_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH (PG_W + 1),
		.AW    (PG_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata ({head_vld_q[tgt_q], head_rd}),
		.re    (ram_re),
		.raddr (head_rd),
		.rdata (ram_rdata)
	);

	// ---- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pg_q <= FIRST_PG_RST;
			pool_top_q <= pcpa_pkg::POOL_TOP_RST;
		end else if (cfg_write_en) begin
			if (cfg_index == pcpa_pkg::REG_POOL_BASE) begin
				first_pg_q <= {1'b0, cfg_data[31:OFF_W]} + FP_W'(|cfg_data[OFF_W-1:0]);
			end else begin
				pool_top_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_we) begin
				head_vld_q[tgt_q] <= head_wvld;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			tgt_q  <= tgt_in;
			none_q <= !(|rot);
			bad_q  <= bad_in;
			idx_q  <= PG_W'(diff);
		end
		if (ram_re) begin
			pop_idx_q <= head_rd;
		end
		if (head_we) begin
			head_q[tgt_q] <= head_wdata;
		end
		if (load_res) begin
			status_q  <= res_status;
			granted_q <= res_granted;
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

endmodule
